/* src/deferred_release_slot_allocator_core_macros.svh */
// Assertion macros shared by the allocator RTL
`ifndef DEFERRED_RELEASE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define DEFERRED_RELEASE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DRSA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRSA_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRSA_ASSERT(label, clk, rst_n, prop, msg)
`define DRSA_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* src/drsa_pkg.sv */
package drsa_pkg;

    localparam int FloatSlotsDef  = 1024;
    localparam int IntSlotsDef    = 32;
    localparam int UintSlotsDef   = 64;
    localparam int RetireDepthDef = 1024;

    localparam int SlotW  = 10;
    localparam int FrameW = 48;
    localparam int ReadyW = 49;
    localparam int OvlW   = 4;

    localparam logic [OvlW-1:0] OverlapReset = 4'd2;

    typedef enum logic [0:0] {
        CMD_ALLOC   = 1'b0,
        CMD_RELEASE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        CAT_FLOAT = 2'd0,
        CAT_INT   = 2'd1,
        CAT_UINT  = 2'd2,
        CAT_ALT   = 2'd3
    } cat_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_SCAN_RD,
        S_SCAN,
        S_POP_RD,
        S_POP,
        S_OUT
    } state_t;

    // Register addresses
    localparam logic [0:0] ADDR_FRAME_OVERLAP = 1'b0;

    typedef struct packed {
        logic [0:0]       command;
        logic [1:0]       category;
        logic [SlotW-1:0] slot_in;
        logic [FrameW-1:0] frame_number;
    } req_t;

    typedef struct packed {
        logic [SlotW-1:0] slot_out;
        logic [1:0]       status;
    } rsp_t;

    // Pool select, category three folds into uint
    function automatic logic [1:0] pool_of(input logic [1:0] cat);
        logic [1:0] p;
        begin
            p = (cat == CAT_FLOAT) ? 2'd0 : ((cat == CAT_INT) ? 2'd1 : 2'd2);
            return p;
        end
    endfunction

endpackage

/* src/drsa_if.sv */
interface drsa_req_if;
    import drsa_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface drsa_rsp_if;
    import drsa_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/drsa_pool.sv */
`include "deferred_release_slot_allocator_core_macros.svh"
// One LIFO free stack: single memory, one write and one registered read per cycle
module drsa_pool #(
    parameter int Slots = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  init_we,
    input  logic [$clog2(Slots+1)-1:0] init_idx,
    input  logic                  push,
    input  logic [drsa_pkg::SlotW-1:0] push_slot,
    input  logic                  pop,
    output logic [$clog2(Slots+1)-1:0] count,
    output logic [drsa_pkg::SlotW-1:0] rd_data
);
    import drsa_pkg::*;
    localparam int CntW = $clog2(Slots+1);
    localparam int AW   = (Slots > 1) ? $clog2(Slots) : 1;

    logic [SlotW-1:0] mem [Slots];
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [SlotW-1:0] rd_reg;
    logic [CntW-1:0]  top;

    assign top = cnt_reg - CntW'(1);

    // count update
    always_comb
    begin
        cnt_next = cnt_reg;
        if (init_we)
            cnt_next = CntW'(Slots);
        else if (push)
            cnt_next = cnt_reg + CntW'(1);
        else if (pop)
            cnt_next = top;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // memory write and top-of-stack read
    always_ff @(posedge clk)
    begin
        if (init_we)
            mem[init_idx[AW-1:0]] <= SlotW'(init_idx);
        else if (push)
            mem[cnt_reg[AW-1:0]] <= push_slot;
        rd_reg <= mem[top[AW-1:0]];
    end

    assign count   = cnt_reg;
    assign rd_data = rd_reg;

    `DRSA_ASSERT(a_no_over, clk, rst_n, cnt_reg <= CntW'(Slots), "pool count over capacity")
    `DRSA_ASSERT(a_push_room, clk, rst_n, push |-> cnt_reg < CntW'(Slots), "push on full pool")
    `DRSA_ASSERT(a_pop_nonempty, clk, rst_n, pop |-> cnt_reg != '0, "pop on empty pool")
endmodule

/* src/deferred_release_slot_allocator_core.sv */
// Channel    | Dir | Payload
// req        | in  | command, category, slot_in, frame_number
// rsp        | out | slot_out, status
// apb        | in  | frame_overlap at address 0
// Release: the result is registered and offered in S_OUT. Allocate: an S_SCAN_RD and
// S_SCAN visit per retire entry held (one queue read and compare each, one memory port),
// then S_POP_RD and S_POP. After reset, a clearing pass fills the pools, with no
// transaction accepted. One transaction in flight; req is not ready until rsp is taken.
`include "deferred_release_slot_allocator_core_macros.svh"
module deferred_release_slot_allocator_core #(
    parameter int FLOAT_SLOTS  = drsa_pkg::FloatSlotsDef,
    parameter int INT_SLOTS    = drsa_pkg::IntSlotsDef,
    parameter int UINT_SLOTS   = drsa_pkg::UintSlotsDef,
    parameter int RETIRE_DEPTH = drsa_pkg::RetireDepthDef
) (
    input  logic        clk,
    input  logic        rst_n,
    drsa_req_if.sink    req,
    drsa_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drsa_pkg::*;

    localparam int FCW = $clog2(FLOAT_SLOTS+1);
    localparam int ICW = $clog2(INT_SLOTS+1);
    localparam int UCW = $clog2(UINT_SLOTS+1);
    localparam int MAXS = (FLOAT_SLOTS > INT_SLOTS)
                        ? ((FLOAT_SLOTS > UINT_SLOTS) ? FLOAT_SLOTS : UINT_SLOTS)
                        : ((INT_SLOTS > UINT_SLOTS) ? INT_SLOTS : UINT_SLOTS);
    localparam int IW  = $clog2(MAXS+1);
    localparam int QCW = $clog2(RETIRE_DEPTH+1);
    localparam int QAW = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
    localparam int EW  = 2 + SlotW + ReadyW;

    // config register
    logic [OvlW-1:0] ovl_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovl_reg <= OverlapReset;
        else if (psel && penable && pwrite && paddr == {ADDR_FRAME_OVERLAP, 1'b0})
            ovl_reg <= pwdata[OvlW-1:0];
    end
    assign pready = 1'b1;
    assign prdata = (paddr == {ADDR_FRAME_OVERLAP, 1'b0}) ? 32'(ovl_reg) : 32'd0;

    // control registers
    state_t          state_reg, state_next;
    req_t            cur_reg, cur_next;
    rsp_t            rsp_reg, rsp_next;
    logic [IW-1:0]   init_reg, init_next;
    logic [QCW-1:0]  qcnt_reg, qcnt_next;
    logic [QCW-1:0]  rd_reg, rd_next;
    logic [QCW-1:0]  kept_reg, kept_next;

    // retire queue memory
    logic [EW-1:0]   qmem [RETIRE_DEPTH];
    logic [EW-1:0]   qrd_reg;
    logic            q_we;
    logic [QAW-1:0]  q_waddr;
    logic [EW-1:0]   q_wdata;

    always_ff @(posedge clk)
    begin
        if (q_we)
            qmem[q_waddr] <= q_wdata;
        qrd_reg <= qmem[rd_reg[QAW-1:0]];
    end

    // pool instances
    logic            f_init, i_init, u_init;
    logic            f_push, i_push, u_push;
    logic            f_pop, i_pop, u_pop;
    logic [FCW-1:0]  f_cnt;
    logic [ICW-1:0]  i_cnt;
    logic [UCW-1:0]  u_cnt;
    logic [SlotW-1:0] f_rd, i_rd, u_rd;
    logic [SlotW-1:0] push_slot;

    drsa_pool #(.Slots(FLOAT_SLOTS)) u_float (
        .clk(clk), .rst_n(rst_n), .init_we(f_init), .init_idx(FCW'(init_reg)),
        .push(f_push), .push_slot(push_slot), .pop(f_pop), .count(f_cnt), .rd_data(f_rd));
    drsa_pool #(.Slots(INT_SLOTS)) u_int (
        .clk(clk), .rst_n(rst_n), .init_we(i_init), .init_idx(ICW'(init_reg)),
        .push(i_push), .push_slot(push_slot), .pop(i_pop), .count(i_cnt), .rd_data(i_rd));
    drsa_pool #(.Slots(UINT_SLOTS)) u_uint (
        .clk(clk), .rst_n(rst_n), .init_we(u_init), .init_idx(UCW'(init_reg)),
        .push(u_push), .push_slot(push_slot), .pop(u_pop), .count(u_cnt), .rd_data(u_rd));

    // decoded queue entry
    logic [1:0]        e_cat, e_pool, c_pool;
    logic [SlotW-1:0]  e_slot;
    logic [ReadyW-1:0] e_ready;
    logic              e_keep, e_fits;
    assign {e_cat, e_slot, e_ready} = qrd_reg;
    assign e_pool = pool_of(e_cat);
    assign c_pool = pool_of(cur_reg.category);
    assign e_keep = e_ready > ReadyW'(cur_reg.frame_number);
    always_comb
    begin
        unique case (e_pool)
            2'd0:    e_fits = 32'(e_slot) < FLOAT_SLOTS && 32'(f_cnt) < FLOAT_SLOTS;
            2'd1:    e_fits = 32'(e_slot) < INT_SLOTS && 32'(i_cnt) < INT_SLOTS;
            default: e_fits = 32'(e_slot) < UINT_SLOTS && 32'(u_cnt) < UINT_SLOTS;
        endcase
    end
    assign push_slot = e_slot;

    logic c_empty;
    always_comb
    begin
        unique case (c_pool)
            2'd0:    c_empty = f_cnt == '0;
            2'd1:    c_empty = i_cnt == '0;
            default: c_empty = u_cnt == '0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        rsp_next   = rsp_reg;
        init_next  = init_reg;
        qcnt_next  = qcnt_reg;
        rd_next    = rd_reg;
        kept_next  = kept_reg;
        q_we = 1'b0; q_waddr = kept_reg[QAW-1:0]; q_wdata = qrd_reg;
        f_init = 1'b0; i_init = 1'b0; u_init = 1'b0;
        f_push = 1'b0; i_push = 1'b0; u_push = 1'b0;
        f_pop = 1'b0; i_pop = 1'b0; u_pop = 1'b0;
        req.ready = 1'b0;
        rsp.valid = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                f_init = 32'(init_reg) < FLOAT_SLOTS;
                i_init = 32'(init_reg) < INT_SLOTS;
                u_init = 32'(init_reg) < UINT_SLOTS;
                init_next = init_reg + IW'(1);
                if (32'(init_reg) == MAXS - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cur_next = req.payload;
                    rd_next = '0;
                    kept_next = '0;
                    if (req.payload.command == CMD_RELEASE)
                    begin
                        if (qcnt_reg >= QCW'(RETIRE_DEPTH))
                            rsp_next = '{slot_out: '0, status: ST_FULL};
                        else
                        begin
                            q_we = 1'b1;
                            q_waddr = qcnt_reg[QAW-1:0];
                            q_wdata = {req.payload.category, req.payload.slot_in,
                                       ReadyW'(req.payload.frame_number)
                                       + ReadyW'(ovl_reg) + ReadyW'(1)};
                            qcnt_next = qcnt_reg + QCW'(1);
                            rsp_next = '{slot_out: '0, status: ST_OK};
                        end
                        state_next = S_OUT;
                    end
                    else
                        state_next = (qcnt_reg == '0) ? S_POP_RD : S_SCAN_RD;
                end
            end
            S_SCAN_RD:
                state_next = S_SCAN;
            S_SCAN:
            begin
                // one entry a visit: compact kept ones, push ready ones that fit, drop the rest
                if (e_keep)
                begin
                    q_we = 1'b1;
                    kept_next = kept_reg + QCW'(1);
                end
                else if (e_fits)
                begin
                    f_push = e_pool == 2'd0;
                    i_push = e_pool == 2'd1;
                    u_push = e_pool == 2'd2;
                end
                rd_next = rd_reg + QCW'(1);
                if (rd_reg + QCW'(1) == qcnt_reg)
                begin
                    qcnt_next = e_keep ? kept_reg + QCW'(1) : kept_reg;
                    state_next = S_POP_RD;
                end
                else
                    state_next = S_SCAN_RD;
            end
            S_POP_RD:
                state_next = S_POP;
            S_POP:
            begin
                if (c_empty)
                    rsp_next = '{slot_out: '0, status: ST_EMPTY};
                else
                begin
                    f_pop = c_pool == 2'd0;
                    i_pop = c_pool == 2'd1;
                    u_pop = c_pool == 2'd2;
                    unique case (c_pool)
                        2'd0:    rsp_next = '{slot_out: f_rd, status: ST_OK};
                        2'd1:    rsp_next = '{slot_out: i_rd, status: ST_OK};
                        default: rsp_next = '{slot_out: u_rd, status: ST_OK};
                    endcase
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end
    assign rsp.payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            init_reg  <= '0;
            qcnt_reg  <= '0;
            rd_reg    <= '0;
            kept_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            init_reg  <= init_next;
            qcnt_reg  <= qcnt_next;
            rd_reg    <= rd_next;
            kept_reg  <= kept_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        rsp_reg <= rsp_next;
    end

    `DRSA_ASSERT(a_q_bound, clk, rst_n, qcnt_reg <= QCW'(RETIRE_DEPTH), "retire count over depth")
    `DRSA_ASSERT(a_kept_bound, clk, rst_n, kept_reg <= rd_reg, "kept index ahead of read index")
    `DRSA_ASSERT(a_one_push, clk, rst_n, $onehot0({f_push, i_push, u_push, f_pop, i_pop, u_pop}), "multiple pool ops")
endmodule

/* bench/tb_deferred_release_slot_allocator_core.sv */
`timescale 1ns / 100ps

module tb_deferred_release_slot_allocator_core;
    import drsa_pkg::*;

    localparam int  CycleLimit       = 20000000;
    localparam logic [1:0] FrameOverlapAddr = 2'd0;
    localparam int  NumPools         = 3;
    localparam int  PoolFloat        = 0;
    localparam int  PoolInt          = 1;
    localparam int  PoolUint         = 2;

    typedef struct {
        int              pool;
        logic [SlotW-1:0] slot;
        logic [ReadyW-1:0] ready_frame;
    } retired_slot_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    drsa_req_if req_ch ();
    drsa_rsp_if rsp_ch ();

    deferred_release_slot_allocator_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow allocator state
    logic [SlotW-1:0] free_stack [NumPools][1024];
    int               free_count [NumPools];
    int               pool_size  [NumPools];
    retired_slot_t    retire_fifo[$];
    logic [OvlW-1:0]  overlap_shadow;
    rsp_t             expected_rsp_q[$];

    int          error_count;
    int          sent_count;
    int          checked_count;
    int          empty_seen;
    int          full_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycle_count;
    logic [FrameW-1:0] frame_base;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("%0t: timeout, %0d results still expected", $time, expected_rsp_q.size());
            $display("tb_deferred_release_slot_allocator_core NOT OK");
            $finish;
        end
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected result slot=%0d status=%0d", $time,
                         rsp_ch.payload.slot_out, rsp_ch.payload.status);
                error_count++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                checked_count++;
                if (rsp_ch.payload.slot_out !== want.slot_out)
                begin
                    $display("%0t: slot_out expected %0d actual %0d", $time,
                             want.slot_out, rsp_ch.payload.slot_out);
                    error_count++;
                end
                if (rsp_ch.payload.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, rsp_ch.payload.status);
                    error_count++;
                end
            end
        end
    end

    function automatic int pool_index(input logic [1:0] cat);
        if (cat == CAT_FLOAT)
            return PoolFloat;
        if (cat == CAT_INT)
            return PoolInt;
        return PoolUint;
    endfunction

    function automatic void reset_allocator_model();
        pool_size[PoolFloat] = FloatSlotsDef;
        pool_size[PoolInt]   = IntSlotsDef;
        pool_size[PoolUint]  = UintSlotsDef;
        for (int p = 0; p < NumPools; p++)
        begin
            for (int i = 0; i < pool_size[p]; i++)
                free_stack[p][i] = SlotW'(i);
            free_count[p] = pool_size[p];
        end
        retire_fifo.delete();
        overlap_shadow = OverlapReset;
    endfunction

    // Return ready retired slots that fit to their pool, drop other ready ones
    function automatic void reclaim_ready(input logic [FrameW-1:0] frame);
        retired_slot_t kept[$];
        foreach (retire_fifo[i])
        begin
            if (retire_fifo[i].ready_frame > {1'b0, frame})
                kept = {kept, retire_fifo[i]};
            else if (retire_fifo[i].slot < pool_size[retire_fifo[i].pool] &&
                     free_count[retire_fifo[i].pool] < pool_size[retire_fifo[i].pool])
            begin
                free_stack[retire_fifo[i].pool][free_count[retire_fifo[i].pool]] =
                    retire_fifo[i].slot;
                free_count[retire_fifo[i].pool]++;
            end
        end
        retire_fifo = kept;
    endfunction

    function automatic rsp_t predict_allocation(input req_t r);
        rsp_t          res;
        retired_slot_t ent;
        int            p;
        res.slot_out = '0;
        res.status   = ST_OK;
        p = pool_index(r.category);
        if (r.command == CMD_ALLOC)
        begin
            reclaim_ready(r.frame_number);
            if (free_count[p] == 0)
            begin
                res.status = ST_EMPTY;
                empty_seen++;
            end
            else
            begin
                free_count[p]--;
                res.slot_out = free_stack[p][free_count[p]];
            end
        end
        else if (retire_fifo.size() >= RetireDepthDef)
        begin
            res.status = ST_FULL;
            full_seen++;
        end
        else
        begin
            ent.pool        = p;
            ent.slot        = r.slot_in;
            ent.ready_frame = {1'b0, r.frame_number} + ReadyW'(overlap_shadow) + 1'b1;
            retire_fifo = {retire_fifo, ent};
        end
        return res;
    endfunction

    // Send one transaction, with a random lead-in gap
    task automatic send_request(input req_t r);
        rsp_t exp_rsp;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        exp_rsp = predict_allocation(r);
        expected_rsp_q = {expected_rsp_q, exp_rsp};
        sent_count++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_overlap(input logic [OvlW-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FrameOverlapAddr;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        overlap_shadow = value;
        // read back
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[OvlW-1:0] !== value)
        begin
            $display("%0t: frame_overlap readback expected %0d actual %0d", $time,
                     value, prdata[OvlW-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic req_t make_req(input cmd_t cmd, input cat_t cat,
                                      input logic [SlotW-1:0] slot,
                                      input logic [FrameW-1:0] frame);
        req_t r;
        r.command      = cmd;
        r.category     = cat;
        r.slot_in      = slot;
        r.frame_number = frame;
        return r;
    endfunction

    // Mostly advancing frames, sometimes a stray one that jumps or goes back
    function automatic req_t random_req();
        logic [1:0]        cat;
        logic [SlotW-1:0]  slot;
        logic [FrameW-1:0] frame;
        cat = 2'($urandom_range(3));
        if ($urandom_range(99) < 80)
            slot = SlotW'($urandom_range(pool_size[pool_index(cat)] - 1));
        else
            slot = SlotW'($urandom_range(1023));
        if ($urandom_range(99) < 6)
            frame = FrameW'({$urandom, $urandom});
        else
        begin
            frame_base = frame_base + FrameW'($urandom_range(3));
            frame = frame_base;
        end
        return make_req(($urandom_range(99) < 45) ? CMD_ALLOC : CMD_RELEASE,
                        cat_t'(cat), slot, frame);
    endfunction

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_request(random_req());
    endtask

    // Pool tops, deferred reuse, stray and duplicate releases, frame extremes
    task automatic test_directed();
        logic [FrameW-1:0] f;
        f = 48'd100;
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, f));
        send_request(make_req(CMD_ALLOC, CAT_INT, 10'h3FF, f));
        send_request(make_req(CMD_ALLOC, CAT_UINT, '0, f));
        send_request(make_req(CMD_ALLOC, CAT_ALT, '0, f));
        send_request(make_req(CMD_RELEASE, CAT_FLOAT, 10'd1023, f));
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, f + 48'd2));
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, f + 48'd3));
        // out of range and duplicate releases are dropped at reclaim
        send_request(make_req(CMD_RELEASE, CAT_INT, 10'd500, f + 48'd3));
        send_request(make_req(CMD_RELEASE, CAT_INT, 10'd31, f + 48'd3));
        send_request(make_req(CMD_RELEASE, CAT_INT, 10'd31, f + 48'd3));
        send_request(make_req(CMD_RELEASE, CAT_ALT, 10'd63, f + 48'd3));
        send_request(make_req(CMD_RELEASE, CAT_UINT, 10'd0, f + 48'd3));
        send_request(make_req(CMD_ALLOC, CAT_INT, '0, f + 48'd10));
        send_request(make_req(CMD_ALLOC, CAT_INT, '0, f + 48'd10));
        send_request(make_req(CMD_ALLOC, CAT_UINT, '0, f + 48'd10));
        // frame going backward, then the top of the frame range
        send_request(make_req(CMD_RELEASE, CAT_FLOAT, 10'd0, 48'd5));
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, 48'd5));
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, 48'd8));
        send_request(make_req(CMD_RELEASE, CAT_UINT, 10'd62, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(CMD_ALLOC, CAT_UINT, '0, 48'hFFFF_FFFF_FFFF));
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, 48'hFFFF_FFFF_FFFF));
        frame_base = f + 48'd10;
    endtask

    // Drain the int pool until it reports empty
    task automatic test_pool_empty();
        for (int i = 0; i < IntSlotsDef + 3; i++)
            send_request(make_req(CMD_ALLOC, CAT_INT, '0, frame_base));
    endtask

    // Release without allocating until the retire queue overflows, then reclaim
    task automatic test_retire_full();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < RetireDepthDef + 6; i++)
            send_request(make_req(CMD_RELEASE, cat_t'(2'($urandom_range(3))),
                                  SlotW'($urandom_range(1023)), frame_base));
        frame_base = frame_base + 48'd20;
        send_request(make_req(CMD_ALLOC, CAT_FLOAT, '0, frame_base));
        send_request(make_req(CMD_ALLOC, CAT_INT, '0, frame_base));
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        error_count    = 0;
        sent_count     = 0;
        checked_count  = 0;
        empty_seen     = 0;
        full_seen      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        frame_base     = '0;
        reset_allocator_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pool_empty();
        write_overlap(4'd0);
        run_random(15, 0, 0);
        write_overlap(4'd15);
        run_random(15, 87, 0);
        write_overlap(4'(1 + $urandom_range(13)));
        run_random(15, 0, 87);
        wait_drained();
        write_overlap(4'd1);
        run_random(15, 6, 6);
        test_retire_full();
        run_random(15, 6, 6);

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Sent %0d transactions, checked %0d results (%0d pool empty, %0d queue full)",
                 sent_count, checked_count, empty_seen, full_seen);
        $display("Covered overlap 0..15, stray and duplicate releases, retire overflow, stalls");
        if (error_count == 0 && expected_rsp_q.size() == 0)
            $display("tb_deferred_release_slot_allocator_core OK");
        else
            $display("tb_deferred_release_slot_allocator_core NOT OK");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/drsa_pkg.sv
src/drsa_if.sv
src/drsa_pool.sv
src/deferred_release_slot_allocator_core.sv
bench/tb_deferred_release_slot_allocator_core.sv
